[design/rrps_pkg.sv]
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared widths, register map and build-time table generators for the
// radial ray and ring pixel shader.
// ----------------------------------------------------------------------------
package rrps_pkg;

    // payload widths
    localparam int ANGLE_W = 14;
    localparam int DEPTH_W = 14;
    localparam int SHADE_W = 6;
    localparam int CHAN_W  = 8;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    // register indexes, register i at byte address 8*i
    localparam logic [2:0] REG_SWEEP     = 3'd0;
    localparam logic [2:0] REG_BEND      = 3'd1;
    localparam logic [2:0] REG_RING      = 3'd2;
    localparam logic [2:0] REG_STOPS_0_1 = 3'd3;
    localparam logic [2:0] REG_STOPS_2_3 = 3'd4;
    localparam logic [2:0] REG_STOPS_4_5 = 3'd5;

    localparam logic [14:0] RING_PHASE_RESET = 15'd16384;

    localparam int SINE_ENTRIES_DEFAULT = 1024;
    localparam int RAMP_ENTRIES         = 256;
    localparam int SHADE_LEVELS         = 64;
    localparam int ENV_W                = 17;

    // 2*pi in q60
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

    localparam int ENV_X [8] = '{0, 18, 36, 52, 62, 72, 86, 100};
    localparam int ENV_Y [8] = '{6, 30, 58, 86, 100, 86, 36, 6};

    typedef logic [ENV_W-1:0] t_env_rom   [RAMP_ENTRIES];
    typedef logic [ENV_W-1:0] t_scale_rom [SHADE_LEVELS];

    // floor(a*b / 2^60), kept to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // restoring long division for the build-time tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // trunc(32767*sin(2*pi*k/n)) for 0 <= k <= n/4, step = 2*pi/n in q60
    function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned qtr,
                                                 input logic [63:0] step);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] res;
        if (k == 0) begin
            return 15'd0;
        end
        if (k >= qtr) begin
            return 15'd32767;
        end
        x    = step * 64'(k);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int unsigned n = 1; n < 16; n++) begin
            term = udiv64(mul_q60(term, x2), 64'(2 * n) * 64'(2 * n + 1));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        res = mul_q60(sum, 64'd32767);
        return res[14:0];
    endfunction

    // piecewise-linear brightness envelope, 16-bit fraction
    function automatic t_env_rom build_env();
        t_env_rom rom;
        int       j;
        longint   i;
        longint   dx;
        longint   num;
        longint   den;
        j = 0;
        for (int k = 0; k < RAMP_ENTRIES; k++) begin
            i = longint'(k);
            while (j < 6 && 100 * i > longint'(ENV_X[j+1]) * (RAMP_ENTRIES - 1)) begin
                j++;
            end
            dx  = longint'(ENV_X[j+1] - ENV_X[j]);
            num = longint'(ENV_Y[j]) * (RAMP_ENTRIES - 1) * dx
                + longint'(ENV_Y[j+1] - ENV_Y[j])
                  * (100 * i - longint'(RAMP_ENTRIES - 1) * ENV_X[j]);
            den = 100 * longint'(RAMP_ENTRIES - 1) * dx;
            rom[k] = (num > 0) ? ENV_W'(udiv64(64'(num * 65536), 64'(den))) : '0;
        end
        return rom;
    endfunction

    // shade * 65536 / 63
    function automatic t_scale_rom build_scale();
        t_scale_rom rom;
        for (int k = 0; k < SHADE_LEVELS; k++) begin
            rom[k] = ENV_W'(udiv64(64'(k * 65536), 64'(SHADE_LEVELS - 1)));
        end
        return rom;
    endfunction

    localparam t_env_rom   ENV_ROM   = build_env();
    localparam t_scale_rom SCALE_ROM = build_scale();

endpackage

[design/rrps_pix_in_if.sv]
// ----------------------------------------------------------------------------
// rrps_pix_in_if
// Pixel input channel: angle phase, depth code and shade level.
// ----------------------------------------------------------------------------
interface rrps_pix_in_if import rrps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_phase;
    logic [DEPTH_W-1:0] depth_code;
    logic [SHADE_W-1:0] shade_level;

    modport source (output valid, output angle_phase, output depth_code,
                    output shade_level, input ready);
    modport sink   (input valid, input angle_phase, input depth_code,
                    input shade_level, output ready);
endinterface

[design/rrps_pix_out_if.sv]
// ----------------------------------------------------------------------------
// rrps_pix_out_if
// Pixel output channel: red, green and blue.
// ----------------------------------------------------------------------------
interface rrps_pix_out_if import rrps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[design/radial_ray_ring_pixel_shader.sv]
// ----------------------------------------------------------------------------
// radial_ray_ring_pixel_shader
// Ray and ring pattern shader: three sine lookups, ramp index, palette
// interpolation, brightness envelope and shade scaling in a ten-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  i_pix     in    valid/ready          angle_phase, depth_code, shade_level
//  o_pix     out   valid/ready          red, green, blue
//  cfg       in    apb psel/penable     paddr[5:3] register, pwdata 64 bits
//
//  one pixel per clock sustained while o_pix is ready; ten registered stages to output
//  every stage has its own valid bit; a stage loads when it is empty or the
//  stage after it moves, so bubbles close up while the output is stalled
//  i_rst_n (sync) clears valid bits and configuration; ring_phase resets to 16384
//  the sine quarter table, envelope and shade scale are constant tables
// ----------------------------------------------------------------------------
module radial_ray_ring_pixel_shader import rrps_pkg::*; #(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rrps_pix_in_if.sink           i_pix,
    rrps_pix_out_if.source        o_pix,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW   = $clog2(SINE_ENTRIES);
    localparam int QW   = AW - 1;
    localparam int QTR  = SINE_ENTRIES / 4;
    localparam int HALF = SINE_ENTRIES / 2;
    localparam int NSTG = 10;
    localparam logic [63:0] SINE_STEP = TWO_PI_Q60 / 64'(SINE_ENTRIES);

    typedef logic [14:0] t_qtab [QTR+1];

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int k = 0; k <= QTR; k++) begin
            tab[k] = quarter_sine(k, QTR, SINE_STEP);
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    // fold a full-turn index onto the quarter table
    function automatic logic [QW-1:0] fold(input logic [AW-1:0] k);
        logic [AW-1:0] m;
        logic [AW-1:0] d;
        m = {1'b0, k[AW-2:0]};
        d = AW'(HALF) - m;
        if (m <= AW'(QTR)) begin
            return m[QW-1:0];
        end
        return d[QW-1:0];
    endfunction

    function automatic logic signed [15:0] signed_sine(input logic [14:0] mag,
                                                       input logic neg);
        logic signed [15:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [13:0] r_sweep;
    logic [13:0] r_bend;
    logic [14:0] r_ring;
    logic [47:0] r_stops01;
    logic [47:0] r_stops23;
    logic [47:0] r_stops45;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= '0;
            r_bend    <= '0;
            r_ring    <= RING_PHASE_RESET;
            r_stops01 <= '0;
            r_stops23 <= '0;
            r_stops45 <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                REG_SWEEP:     r_sweep   <= pwdata[13:0];
                REG_BEND:      r_bend    <= pwdata[13:0];
                REG_RING:      r_ring    <= pwdata[14:0];
                REG_STOPS_0_1: r_stops01 <= pwdata[47:0];
                REG_STOPS_2_3: r_stops23 <= pwdata[47:0];
                REG_STOPS_4_5: r_stops45 <= pwdata[47:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_SWEEP:     prdata = {50'd0, r_sweep};
            REG_BEND:      prdata = {50'd0, r_bend};
            REG_RING:      prdata = {49'd0, r_ring};
            REG_STOPS_0_1: prdata = {16'd0, r_stops01};
            REG_STOPS_2_3: prdata = {16'd0, r_stops23};
            REG_STOPS_4_5: prdata = {16'd0, r_stops45};
            default:       prdata = '0;
        endcase
    end

    function automatic logic [23:0] stop_colour(input logic [2:0] j);
        case (j)
            3'd0:    return r_stops01[23:0];
            3'd1:    return r_stops01[47:24];
            3'd2:    return r_stops23[23:0];
            3'd3:    return r_stops23[47:24];
            3'd4:    return r_stops45[23:0];
            3'd5:    return r_stops45[47:24];
            default: return 24'd0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stall control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || o_pix.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_pix.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: depth phases and angle plus sweep
    // ------------------------------------------------------------------
    logic [20:0]        w_bend_mul;
    logic [24:0]        w_ring_mul;
    logic [15:0]        w_bend_ph;
    logic [19:0]        w_ring_ph;
    logic [AW-1:0]      n_s1_bend_idx;
    logic [AW-1:0]      n_s1_ring_idx;
    logic [14:0]        n_s1_angsw;
    logic [AW-1:0]      r_s1_bend_idx;
    logic [AW-1:0]      r_s1_ring_idx;
    logic [14:0]        r_s1_angsw;
    logic [SHADE_W-1:0] r_s1_shade;

    assign w_bend_mul    = 21'(i_pix.depth_code) * 21'd117;
    assign w_ring_mul    = 25'(i_pix.depth_code) * 25'd1173;
    assign w_bend_ph     = 16'(w_bend_mul[20:6]) + 16'(r_bend);
    assign w_ring_ph     = 20'(w_ring_mul[24:6]) + 20'(r_ring);
    assign n_s1_bend_idx = w_bend_ph[4 +: AW];
    assign n_s1_ring_idx = w_ring_ph[4 +: AW];
    assign n_s1_angsw    = 15'(i_pix.angle_phase) + 15'(r_sweep);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_bend_idx <= n_s1_bend_idx;
            r_s1_ring_idx <= n_s1_ring_idx;
            r_s1_angsw    <= n_s1_angsw;
            r_s1_shade    <= i_pix.shade_level;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: bend and ring sine lookups
    // ------------------------------------------------------------------
    logic [14:0]        r_s2_bend_mag;
    logic               r_s2_bend_neg;
    logic [14:0]        r_s2_ring_mag;
    logic               r_s2_ring_neg;
    logic [14:0]        r_s2_angsw;
    logic [SHADE_W-1:0] r_s2_shade;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_bend_mag <= QTAB[fold(r_s1_bend_idx)];
            r_s2_bend_neg <= r_s1_bend_idx[AW-1];
            r_s2_ring_mag <= QTAB[fold(r_s1_ring_idx)];
            r_s2_ring_neg <= r_s1_ring_idx[AW-1];
            r_s2_angsw    <= r_s1_angsw;
            r_s2_shade    <= r_s1_shade;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: bend scaling and ray phase
    // ------------------------------------------------------------------
    logic signed [27:0] w_bend_prod;
    logic signed [12:0] w_bend;
    logic signed [16:0] w_ray_ph;
    logic [AW-1:0]      r_s3_ray_idx;
    logic signed [15:0] r_s3_ring_val;
    logic [SHADE_W-1:0] r_s3_shade;

    assign w_bend_prod = 28'(signed_sine(r_s2_bend_mag, r_s2_bend_neg)) * 28'sd1434;
    assign w_bend      = $signed(w_bend_prod[27:15]);
    // ray phase may go negative; the low bits still wrap correctly
    assign w_ray_ph    = $signed({2'b00, r_s2_angsw}) + $signed({{4{w_bend[12]}}, w_bend});

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_ray_idx  <= w_ray_ph[4 +: AW];
            r_s3_ring_val <= signed_sine(r_s2_ring_mag, r_s2_ring_neg);
            r_s3_shade    <= r_s2_shade;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: ray sine lookup
    // ------------------------------------------------------------------
    logic [14:0]        r_s4_ray_mag;
    logic               r_s4_ray_neg;
    logic signed [15:0] r_s4_ring_val;
    logic [SHADE_W-1:0] r_s4_shade;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4_ray_mag  <= QTAB[fold(r_s3_ray_idx)];
            r_s4_ray_neg  <= r_s3_ray_idx[AW-1];
            r_s4_ring_val <= r_s3_ring_val;
            r_s4_shade    <= r_s3_shade;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: ray and ring mix
    // ------------------------------------------------------------------
    logic signed [23:0] w_mix;
    logic signed [15:0] r_s5_field;
    logic [SHADE_W-1:0] r_s5_shade;

    assign w_mix = 24'(signed_sine(r_s4_ray_mag, r_s4_ray_neg)) * 24'sd79
                 + 24'(r_s4_ring_val) * 24'sd49;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s5_field <= $signed(w_mix[22:7]);
            r_s5_shade <= r_s4_shade;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: ramp index
    // ------------------------------------------------------------------
    logic signed [23:0] w_idx_prod;
    logic [7:0]         r_s6_idx;
    logic [SHADE_W-1:0] r_s6_shade;

    assign w_idx_prod = 24'(r_s5_field) * 24'sd118;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s6_idx   <= w_idx_prod[22:15] + 8'd128;
            r_s6_shade <= r_s5_shade;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: palette stops, envelope and shade scale
    // ------------------------------------------------------------------
    logic [10:0]      w_q;
    logic [2:0]       w_j0;
    logic [2:0]       w_j1;
    logic [23:0]      r_s7_a;
    logic [23:0]      r_s7_b;
    logic [7:0]       r_s7_f;
    logic [ENV_W-1:0] r_s7_env;
    logic [ENV_W-1:0] r_s7_scale;

    assign w_q  = 11'(r_s6_idx) * 11'd6;
    assign w_j0 = w_q[10:8];
    // the last stop wraps back to the first
    assign w_j1 = (w_j0 == 3'd5) ? 3'd0 : w_j0 + 3'd1;

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_s7_a     <= stop_colour(w_j0);
            r_s7_b     <= stop_colour(w_j1);
            r_s7_f     <= w_q[7:0];
            r_s7_env   <= ENV_ROM[r_s6_idx];
            r_s7_scale <= SCALE_ROM[r_s6_shade];
        end
    end

    // ------------------------------------------------------------------
    // stage 8: interpolation between stops
    // ------------------------------------------------------------------
    logic [23:0]      n_s8_v;
    logic [23:0]      r_s8_v;
    logic [ENV_W-1:0] r_s8_env;
    logic [ENV_W-1:0] r_s8_scale;

    always_comb begin
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic [9:0]         sum;
        for (int ch = 0; ch < 3; ch++) begin
            diff = $signed({1'b0, r_s7_b[ch*8 +: 8]}) - $signed({1'b0, r_s7_a[ch*8 +: 8]});
            prod = 18'(diff) * $signed({10'd0, r_s7_f});
            sum  = {2'b00, r_s7_a[ch*8 +: 8]} + prod[17:8];
            n_s8_v[ch*8 +: 8] = sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r_s8_v     <= n_s8_v;
            r_s8_env   <= r_s7_env;
            r_s8_scale <= r_s7_scale;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: brightness envelope
    // ------------------------------------------------------------------
    logic [23:0]      n_s9_v;
    logic [23:0]      r_s9_v;
    logic [ENV_W-1:0] r_s9_scale;

    always_comb begin
        logic [24:0] p;
        for (int ch = 0; ch < 3; ch++) begin
            p = 25'(r_s8_v[ch*8 +: 8]) * 25'(r_s8_env);
            n_s9_v[ch*8 +: 8] = p[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r_s9_v     <= n_s9_v;
            r_s9_scale <= r_s8_scale;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: shade scaling, output register
    // ------------------------------------------------------------------
    logic [23:0] n_s10_rgb;
    logic [23:0] r_s10_rgb;

    always_comb begin
        logic [24:0] p;
        for (int ch = 0; ch < 3; ch++) begin
            p = 25'(r_s9_v[ch*8 +: 8]) * 25'(r_s9_scale);
            n_s10_rgb[ch*8 +: 8] = p[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[9]) begin
            r_s10_rgb <= n_s10_rgb;
        end
    end

    assign o_pix.valid = r_vld[NSTG-1];
    assign o_pix.red   = r_s10_rgb[23:16];
    assign o_pix.green = r_s10_rgb[15:8];
    assign o_pix.blue  = r_s10_rgb[7:0];

endmodule
